[hdl/normalized_conv3x3_minmax_macros.svh]
// Assertion helpers for the checker file.
`ifndef NORMALIZED_CONV3X3_MINMAX_MACROS_SVH
`define NORMALIZED_CONV3X3_MINMAX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NCMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ncmm_pkg.sv]
`timescale 1ns / 1ps
package ncmm_pkg;
	localparam int MAX_W      = 256;
	localparam int MAX_H      = 256;
	localparam int DIM_W      = 9;
	localparam int ADDR_W     = $clog2(MAX_W * MAX_H);
	localparam int SIZE_W     = ADDR_W + 1;
	localparam int PIX_W      = 8;
	localparam int COEF_W     = 8;
	localparam int KROW_W     = 24;
	localparam int KSUM_W     = 12;
	localparam int DVS_W      = 11;
	localparam int SUM_W      = 20;
	localparam int MUL_W      = 32;
	localparam int DIVN_W     = 30;
	localparam int DIVD_W     = 22;
	localparam int DIV_CNT_W  = $clog2(DIVN_W);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KROW0  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KROW1  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KROW2  = 3'd4;

	localparam logic [DIM_W-1:0]  WIDTH_RST  = 9'd256;
	localparam logic [DIM_W-1:0]  HEIGHT_RST = 9'd256;
	localparam logic [KROW_W-1:0] KROW0_RST  = 24'd65791;
	localparam logic [KROW_W-1:0] KROW1_RST  = 24'd131326;
	localparam logic [KROW_W-1:0] KROW2_RST  = 24'd65791;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_TAP_RD,
		ST_TAP_MAC,
		ST_SUM_WR,
		ST_SWEEP_DIV,
		ST_MINMAX,
		ST_READY,
		ST_RD_SUB,
		ST_RD_DIV_GO,
		ST_RD_DIV,
		ST_RD_OUT
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic frame_clr;
		logic sweep_init;
		logic tap_rd;
		logic tap_mac;
		logic sum_wr;
		logic minmax;
		logic rd_mem;
		logic rd_sub;
		logic rd_div;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic load_last;
		logic tap_last;
		logic pix_last;
		logic div_done;
		logic rd_last;
		logic skip_div;
		logic out_free;
	} sts_t;

	// Width or height register value as used: zero acts as one, large values saturate.
	function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] mx);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > mx)
			r = mx;
		else
			r = v;
		return r;
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_at(input logic [KROW_W-1:0] row,
			input logic [1:0] col);
		logic signed [COEF_W-1:0] c;
		c = $signed(row[col*COEF_W +: COEF_W]);
		return c;
	endfunction
endpackage

[hdl/ncmm_if.sv]
`timescale 1ns / 1ps
interface ncmm_in_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [ncmm_pkg::PIX_W-1:0]     pixel_in;

	modport source(output valid, output op, output pixel_in, input ready);
	modport sink(input valid, input op, input pixel_in, output ready);
endinterface

interface ncmm_out_if;
	logic                           valid;
	logic                           ready;
	logic [ncmm_pkg::PIX_W-1:0]     pixel_out;
	logic                           last_pixel;
	logic                           flat_frame;

	modport source(output valid, output pixel_out, output last_pixel, output flat_frame,
		input ready);
	modport sink(input valid, input pixel_out, input last_pixel, input flat_frame,
		output ready);
endinterface

[hdl/ncmm_div.sv]
`timescale 1ns / 1ps
module ncmm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ncmm_pkg::DIVN_W-1:0]   dividend,
	input  logic [ncmm_pkg::DIVD_W-1:0]   divisor,
	output logic                          done,
	output logic [ncmm_pkg::DIVN_W-1:0]   quotient
);
	logic [ncmm_pkg::DIVD_W-1:0]    den_q;
	logic [ncmm_pkg::DIVD_W-1:0]    rem_q;
	logic [ncmm_pkg::DIVN_W-1:0]    quo_q;
	logic [ncmm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [ncmm_pkg::DIVD_W:0]      rem_sh;
	logic [ncmm_pkg::DIVD_W:0]      rem_sub;
	logic                           ge;

	// Restoring division, one quotient bit per cycle, MSB first.
	always_comb begin
		rem_sh  = {rem_q, quo_q[ncmm_pkg::DIVN_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ncmm_pkg::DIV_CNT_W'(ncmm_pkg::DIVN_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[ncmm_pkg::DIVD_W-1:0] : rem_sh[ncmm_pkg::DIVD_W-1:0];
			quo_q <= {quo_q[ncmm_pkg::DIVN_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

[hdl/ncmm_ctrl.sv]
`timescale 1ns / 1ps
module ncmm_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ncmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                             in_valid,
	input  logic                             in_op,
	output logic                             in_ready,
	input  ncmm_pkg::sts_t                   sts,
	output ncmm_pkg::cmd_t                   cmd
);
	ncmm_pkg::state_t state_q;
	ncmm_pkg::state_t state_nxt;
	logic             cfg_hit;
	logic             accept;

	// Only writes to a defined register restart the frame.
	assign cfg_hit = cfg_we && (cfg_index == ncmm_pkg::REG_WIDTH ||
		cfg_index == ncmm_pkg::REG_HEIGHT || cfg_index == ncmm_pkg::REG_KROW0 ||
		cfg_index == ncmm_pkg::REG_KROW1 || cfg_index == ncmm_pkg::REG_KROW2);

	assign in_ready = !cfg_hit &&
		(state_q == ncmm_pkg::ST_LOAD || state_q == ncmm_pkg::ST_READY);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ncmm_pkg::ST_LOAD;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		if (cfg_hit) begin
			state_nxt = ncmm_pkg::ST_LOAD;
		end else begin
			unique case (state_q)
				ncmm_pkg::ST_LOAD: begin
					if (accept && in_op == ncmm_pkg::OP_LOAD && sts.load_last)
						state_nxt = ncmm_pkg::ST_TAP_RD;
				end
				ncmm_pkg::ST_TAP_RD: state_nxt = ncmm_pkg::ST_TAP_MAC;
				ncmm_pkg::ST_TAP_MAC: begin
					state_nxt = sts.tap_last ? ncmm_pkg::ST_SUM_WR : ncmm_pkg::ST_TAP_RD;
				end
				ncmm_pkg::ST_SUM_WR: state_nxt = ncmm_pkg::ST_SWEEP_DIV;
				ncmm_pkg::ST_SWEEP_DIV: begin
					if (sts.div_done)
						state_nxt = ncmm_pkg::ST_MINMAX;
				end
				ncmm_pkg::ST_MINMAX: begin
					state_nxt = sts.pix_last ? ncmm_pkg::ST_READY : ncmm_pkg::ST_TAP_RD;
				end
				ncmm_pkg::ST_READY: begin
					if (accept && in_op == ncmm_pkg::OP_READ)
						state_nxt = ncmm_pkg::ST_RD_SUB;
				end
				ncmm_pkg::ST_RD_SUB: state_nxt = ncmm_pkg::ST_RD_DIV_GO;
				ncmm_pkg::ST_RD_DIV_GO: begin
					state_nxt = sts.skip_div ? ncmm_pkg::ST_RD_OUT : ncmm_pkg::ST_RD_DIV;
				end
				ncmm_pkg::ST_RD_DIV: begin
					if (sts.div_done)
						state_nxt = ncmm_pkg::ST_RD_OUT;
				end
				ncmm_pkg::ST_RD_OUT: begin
					if (sts.out_free)
						state_nxt = sts.rd_last ? ncmm_pkg::ST_LOAD : ncmm_pkg::ST_READY;
				end
				default: state_nxt = ncmm_pkg::ST_LOAD;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		if (cfg_hit) begin
			cmd.frame_clr = 1'b1;
		end else begin
			unique case (state_q)
				ncmm_pkg::ST_LOAD: begin
					if (accept && in_op == ncmm_pkg::OP_LOAD) begin
						cmd.load_wr    = 1'b1;
						cmd.sweep_init = sts.load_last;
					end
				end
				ncmm_pkg::ST_TAP_RD:  cmd.tap_rd  = 1'b1;
				ncmm_pkg::ST_TAP_MAC: cmd.tap_mac = 1'b1;
				ncmm_pkg::ST_SUM_WR:  cmd.sum_wr  = 1'b1;
				ncmm_pkg::ST_SWEEP_DIV: begin
				end
				ncmm_pkg::ST_MINMAX:  cmd.minmax  = 1'b1;
				ncmm_pkg::ST_READY: begin
					if (accept && in_op == ncmm_pkg::OP_READ)
						cmd.rd_mem = 1'b1;
				end
				ncmm_pkg::ST_RD_SUB:  cmd.rd_sub  = 1'b1;
				ncmm_pkg::ST_RD_DIV_GO: cmd.rd_div = !sts.skip_div;
				ncmm_pkg::ST_RD_DIV: begin
				end
				ncmm_pkg::ST_RD_OUT: begin
					if (sts.out_free) begin
						cmd.out_load  = 1'b1;
						cmd.frame_clr = sts.rd_last;
					end
				end
				default: cmd = '0;
			endcase
		end
	end
endmodule

[hdl/ncmm_dp.sv]
`timescale 1ns / 1ps
module ncmm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ncmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ncmm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [ncmm_pkg::PIX_W-1:0]        pixel_in,
	input  ncmm_pkg::cmd_t                    cmd,
	output ncmm_pkg::sts_t                    sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [ncmm_pkg::PIX_W-1:0]        pixel_out,
	output logic                              last_pixel,
	output logic                              flat_frame
);
	localparam int DEPTH = ncmm_pkg::MAX_W * ncmm_pkg::MAX_H;
	localparam int AW    = ncmm_pkg::ADDR_W;
	localparam int TAP_W = AW + 2;

	// Configuration registers.
	logic [ncmm_pkg::DIM_W-1:0]  width_q;
	logic [ncmm_pkg::DIM_W-1:0]  height_q;
	logic [ncmm_pkg::KROW_W-1:0] krow_q [3];

	// Frame memories.
	logic [ncmm_pkg::PIX_W-1:0]        pix_mem [DEPTH];
	logic signed [ncmm_pkg::SUM_W-1:0] sum_mem [DEPTH];
	logic [ncmm_pkg::PIX_W-1:0]        pix_rd_q;
	logic signed [ncmm_pkg::SUM_W-1:0] sum_rd_q;

	logic [ncmm_pkg::DIM_W-1:0]  w_eff;
	logic [ncmm_pkg::DIM_W-1:0]  h_eff;
	logic [ncmm_pkg::SIZE_W-1:0] size_m1;
	logic [2*ncmm_pkg::DIM_W-1:0] size_full;

	logic signed [ncmm_pkg::KSUM_W-1:0] row_sum [3];
	logic signed [ncmm_pkg::KSUM_W-1:0] ksum;
	logic [ncmm_pkg::DVS_W-1:0]         dvs;

	// Sweep counters.
	logic [AW-1:0]                     load_cnt_q;
	logic [AW-1:0]                     rd_cnt_q;
	logic [AW-1:0]                     pix_idx_q;
	logic [ncmm_pkg::DIM_W-1:0]        row_q;
	logic [ncmm_pkg::DIM_W-1:0]        col_q;
	logic [1:0]                        kr_q;
	logic [1:0]                        kc_q;
	logic signed [ncmm_pkg::SUM_W-1:0] acc_q;
	logic                              tap_ok_s1;
	logic signed [ncmm_pkg::COEF_W-1:0] coef_s1;
	logic                              neg_q;
	logic                              first_q;
	logic signed [ncmm_pkg::SUM_W-1:0] min_q;
	logic signed [ncmm_pkg::SUM_W-1:0] max_q;
	logic signed [ncmm_pkg::MUL_W-1:0] mnd_q;
	logic [ncmm_pkg::DIVD_W-1:0]       den_q;
	logic signed [ncmm_pkg::MUL_W-1:0] diff_q;

	logic signed [ncmm_pkg::DIM_W:0]   tap_row;
	logic signed [ncmm_pkg::DIM_W:0]   tap_col;
	logic                              tap_ok;
	logic [TAP_W-1:0]                  tap_addr;
	logic [TAP_W-1:0]                  row_off;
	logic signed [ncmm_pkg::PIX_W+ncmm_pkg::COEF_W:0] prod;
	logic [ncmm_pkg::SUM_W-1:0]        acc_mag;
	logic signed [ncmm_pkg::SUM_W-1:0] quo_s;
	logic signed [ncmm_pkg::MUL_W-1:0] span;
	logic signed [ncmm_pkg::MUL_W-1:0] den_full;
	logic signed [ncmm_pkg::MUL_W+8:0] num_full;
	logic [ncmm_pkg::DIVN_W-1:0]       div_a;
	logic [ncmm_pkg::DIVD_W-1:0]       div_b;
	logic                              div_start;
	logic                              div_done;
	logic [ncmm_pkg::DIVN_W-1:0]       div_q;
	logic                              flat;

	logic                              out_valid_q;
	logic [ncmm_pkg::PIX_W-1:0]        pix_out_q;
	logic                              last_q;
	logic                              flat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ncmm_pkg::WIDTH_RST;
			height_q <= ncmm_pkg::HEIGHT_RST;
			krow_q[0] <= ncmm_pkg::KROW0_RST;
			krow_q[1] <= ncmm_pkg::KROW1_RST;
			krow_q[2] <= ncmm_pkg::KROW2_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ncmm_pkg::REG_WIDTH:  width_q   <= cfg_data[ncmm_pkg::DIM_W-1:0];
				ncmm_pkg::REG_HEIGHT: height_q  <= cfg_data[ncmm_pkg::DIM_W-1:0];
				ncmm_pkg::REG_KROW0:  krow_q[0] <= cfg_data;
				ncmm_pkg::REG_KROW1:  krow_q[1] <= cfg_data;
				ncmm_pkg::REG_KROW2:  krow_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign w_eff     = ncmm_pkg::dim_clamp(width_q, ncmm_pkg::DIM_W'(ncmm_pkg::MAX_W));
	assign h_eff     = ncmm_pkg::dim_clamp(height_q, ncmm_pkg::DIM_W'(ncmm_pkg::MAX_H));
	assign size_full = w_eff * h_eff;
	assign size_m1   = size_full[ncmm_pkg::SIZE_W-1:0] - 1'b1;

	// Kernel sum gives the divisor; a sum that is not positive divides by one.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = ncmm_pkg::KSUM_W'(ncmm_pkg::coef_at(krow_q[i], 2'd0))
				+ ncmm_pkg::KSUM_W'(ncmm_pkg::coef_at(krow_q[i], 2'd1))
				+ ncmm_pkg::KSUM_W'(ncmm_pkg::coef_at(krow_q[i], 2'd2));
		end
		ksum = row_sum[0] + row_sum[1] + row_sum[2];
		dvs  = (ksum <= 0) ? ncmm_pkg::DVS_W'(1) : ksum[ncmm_pkg::DVS_W-1:0];
	end

	// Neighbor address for the current kernel tap.
	always_comb begin
		tap_row = $signed({1'b0, row_q}) + $signed({{(ncmm_pkg::DIM_W-1){1'b0}}, kr_q})
			- (ncmm_pkg::DIM_W+1)'(1);
		tap_col = $signed({1'b0, col_q}) + $signed({{(ncmm_pkg::DIM_W-1){1'b0}}, kc_q})
			- (ncmm_pkg::DIM_W+1)'(1);
		tap_ok  = !tap_row[ncmm_pkg::DIM_W] && (tap_row[ncmm_pkg::DIM_W-1:0] < h_eff) &&
			!tap_col[ncmm_pkg::DIM_W] && (tap_col[ncmm_pkg::DIM_W-1:0] < w_eff);
		case (kr_q)
			2'd0:    row_off = '0 - TAP_W'(w_eff);
			2'd2:    row_off = TAP_W'(w_eff);
			default: row_off = '0;
		endcase
		tap_addr = TAP_W'(pix_idx_q) + TAP_W'(kc_q) - TAP_W'(1) + row_off;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			pix_mem[load_cnt_q] <= pixel_in;
		if (cmd.tap_rd)
			pix_rd_q <= pix_mem[tap_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_wr)
			sum_mem[pix_idx_q] <= acc_q;
		if (cmd.rd_mem)
			sum_rd_q <= sum_mem[rd_cnt_q];
	end

	assign prod    = $signed({1'b0, pix_rd_q}) * coef_s1;
	assign acc_mag = acc_q[ncmm_pkg::SUM_W-1] ? ncmm_pkg::SUM_W'(-acc_q)
		: ncmm_pkg::SUM_W'(acc_q);
	assign quo_s   = neg_q ? -$signed(div_q[ncmm_pkg::SUM_W-1:0])
		: $signed(div_q[ncmm_pkg::SUM_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			rd_cnt_q   <= '0;
			pix_idx_q  <= '0;
			row_q      <= '0;
			col_q      <= '0;
			kr_q       <= '0;
			kc_q       <= '0;
			first_q    <= 1'b1;
			min_q      <= '0;
			max_q      <= '0;
		end else begin
			if (cmd.frame_clr) begin
				load_cnt_q <= '0;
				rd_cnt_q   <= '0;
			end else begin
				if (cmd.load_wr)
					load_cnt_q <= load_cnt_q + 1'b1;
				if (cmd.out_load)
					rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (cmd.sweep_init) begin
				pix_idx_q <= '0;
				row_q     <= '0;
				col_q     <= '0;
				kr_q      <= '0;
				kc_q      <= '0;
				first_q   <= 1'b1;
			end
			if (cmd.tap_mac) begin
				if (kc_q == 2'd2) begin
					kc_q <= '0;
					kr_q <= kr_q + 1'b1;
				end else begin
					kc_q <= kc_q + 1'b1;
				end
			end
			if (cmd.minmax) begin
				kr_q      <= '0;
				kc_q      <= '0;
				first_q   <= 1'b0;
				pix_idx_q <= pix_idx_q + 1'b1;
				if (col_q == w_eff - 1'b1) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				if (first_q || quo_s < min_q)
					min_q <= quo_s;
				if (first_q || quo_s > max_q)
					max_q <= quo_s;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_init || cmd.minmax)
			acc_q <= '0;
		else if (cmd.tap_mac && tap_ok_s1)
			acc_q <= acc_q + ncmm_pkg::SUM_W'(prod);
		if (cmd.tap_rd) begin
			tap_ok_s1 <= tap_ok;
			coef_s1   <= ncmm_pkg::coef_at(krow_q[kr_q], kc_q);
		end
		if (cmd.sum_wr)
			neg_q <= acc_q[ncmm_pkg::SUM_W-1];
		if (cmd.rd_sub)
			diff_q <= ncmm_pkg::MUL_W'(sum_rd_q) - mnd_q;
	end

	// Stretch constants, recomputed every cycle from the frame extremes.
	assign span     = ncmm_pkg::MUL_W'(max_q) - ncmm_pkg::MUL_W'(min_q);
	assign den_full = span * $signed({1'b0, dvs});

	always_ff @(posedge clk) begin
		mnd_q <= ncmm_pkg::MUL_W'(min_q * $signed({1'b0, dvs}));
		den_q <= den_full[ncmm_pkg::DIVD_W-1:0];
	end

	// Multiply by 255 as a shift and a subtract.
	assign num_full = ($signed({diff_q, 8'd0}) - (ncmm_pkg::MUL_W+9)'(diff_q));

	always_comb begin
		div_start = cmd.sum_wr || cmd.rd_div;
		if (cmd.sum_wr) begin
			div_a = ncmm_pkg::DIVN_W'(acc_mag);
			div_b = ncmm_pkg::DIVD_W'(dvs);
		end else begin
			div_a = num_full[ncmm_pkg::DIVN_W-1:0];
			div_b = den_q;
		end
	end

	ncmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	assign flat = (max_q == min_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			flat_q <= flat;
			last_q <= (ncmm_pkg::SIZE_W'(rd_cnt_q) == size_m1);
			if (flat || diff_q[ncmm_pkg::MUL_W-1])
				pix_out_q <= '0;
			else if (div_q > ncmm_pkg::DIVN_W'(ncmm_pkg::PIX_MAX))
				pix_out_q <= ncmm_pkg::PIX_MAX;
			else
				pix_out_q <= div_q[ncmm_pkg::PIX_W-1:0];
		end
	end

	always_comb begin
		sts.load_last = ncmm_pkg::SIZE_W'(load_cnt_q) == size_m1;
		sts.tap_last  = (kr_q == 2'd2) && (kc_q == 2'd2);
		sts.pix_last  = ncmm_pkg::SIZE_W'(pix_idx_q) == size_m1;
		sts.div_done  = div_done;
		sts.rd_last   = ncmm_pkg::SIZE_W'(rd_cnt_q) == size_m1;
		sts.skip_div  = flat || diff_q[ncmm_pkg::MUL_W-1];
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pix_out_q;
	assign last_pixel = last_q;
	assign flat_frame = flat_q;
endmodule

[hdl/normalized_conv3x3_minmax.sv]
`timescale 1ns / 1ps
// Each accepted load writes one pixel; the last load of a frame starts the convolution sweep,
// which for each pixel runs nine taps, each a read and a multiply-accumulate through the single
// frame memory port, then a sum write that starts the 30-step division, and an extremes update.
// A read runs a subtract and the division, skipped when the frame is flat or the sum lies below
// the minimum; the next read can be taken in the cycle after its word is loaded to the output.
// Reset restores the register defaults and empties the frame; the memories are not cleared.
module normalized_conv3x3_minmax (
	input  logic                             clk,
	input  logic                             arst_n,
	ncmm_in_if.sink                          in_ch,
	ncmm_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [ncmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ncmm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	ncmm_pkg::cmd_t cmd;
	ncmm_pkg::sts_t sts;

	ncmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ncmm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_in   (in_ch.pixel_in),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.pixel_out  (out_ch.pixel_out),
		.last_pixel (out_ch.last_pixel),
		.flat_frame (out_ch.flat_frame)
	);
endmodule

[hdl/ncmm_checker.sv]
`timescale 1ns / 1ps
`include "normalized_conv3x3_minmax_macros.svh"
module ncmm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_op,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ncmm_pkg::PIX_W-1:0]    pixel_out,
	input logic                          last_pixel,
	input logic                          flat_frame
);
	`NCMM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(last_pixel) && $stable(flat_frame), "stalled word changed")
	`NCMM_ASSERT_IMP(a_flat_zero, clk, arst_n, out_valid && flat_frame, pixel_out == 8'd0, "flat frame word is not zero")
	`NCMM_ASSERT_NXT(a_last_gap, clk, arst_n, out_valid && out_ready && last_pixel, !out_valid, "word follows the last pixel of a frame")
	`NCMM_ASSERT_NXT(a_load_quiet, clk, arst_n, in_valid && in_ready && in_op == ncmm_pkg::OP_LOAD, !$rose(out_valid), "load produced a word")
endmodule

bind normalized_conv3x3_minmax ncmm_checker u_ncmm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_op      (in_ch.op),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.pixel_out  (out_ch.pixel_out),
	.last_pixel (out_ch.last_pixel),
	.flat_frame (out_ch.flat_frame)
);
